>>> src/ffha_pkg.sv
// Shared constants, codes and types of the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    localparam int POOL_BYTES_DEF   = 1048576;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int MAX_SEGMENTS_DEF = 1024;

    localparam int CMD_W  = 2;
    localparam int REQ_W  = 21;
    localparam int NEED_W = REQ_W + 1;
    localparam int ADDR_W = 20;
    localparam int SUM_W  = 21;
    localparam int CALC_W = 32;

    localparam int GRAN      = 4;
    localparam int GRAN_MASK = 3;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_STATS = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_DONE
    } state_t;

    typedef struct packed {
        logic pop;
        logic push;
    } chain_ctl_t;

endpackage

`default_nettype wire

>>> src/ffha_if.sv
// Request and result channel interfaces of the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
    logic                        valid;
    logic                        ready;
    logic [ffha_pkg::CMD_W-1:0]  command;
    logic [ffha_pkg::REQ_W-1:0]  request_bytes;
    logic [ffha_pkg::ADDR_W-1:0] payload_offset;

    modport source(output valid, command, request_bytes, payload_offset, input ready);
    modport sink(input valid, command, request_bytes, payload_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [ffha_pkg::ADDR_W-1:0] granted_offset;
    logic [ffha_pkg::SUM_W-1:0]  total_bytes;
    logic [ffha_pkg::SUM_W-1:0]  spare_bytes;

    modport source(output valid, status, granted_offset, total_bytes, spare_bytes, input ready);
    modport sink(input valid, status, granted_offset, total_bytes, spare_bytes, output ready);
endinterface

`default_nettype wire

>>> src/ffha_cell.sv
// One cell of the segment chain: holds one segment entry.
`timescale 1ns / 1ps
`default_nettype none

module ffha_cell #(
    parameter int              EW      = 41,
    parameter int              CNT_W   = 11,
    parameter int              IDX     = 0,
    parameter logic [EW-1:0]   RST_VAL = '0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop,
    input  wire logic             push,
    input  wire logic [CNT_W-1:0] tail,
    input  wire logic [EW-1:0]    din,
    input  wire logic [EW-1:0]    right,
    output logic      [EW-1:0]    q
);

    logic          at_tail;
    logic [EW-1:0] q_reg;
    logic [EW-1:0] q_next;

    assign at_tail = push && (tail == CNT_W'(IDX));

    always_comb
    begin
        q_next = q_reg;
        if (at_tail)
        begin
            q_next = din;
        end
        else if (pop)
        begin
            q_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= RST_VAL;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

>>> src/ffha_chain.sv
// Row of segment cells working as a shifting queue with its fill count.
`timescale 1ns / 1ps
`default_nettype none

module ffha_chain #(
    parameter int            N     = 1024,
    parameter int            EW    = 41,
    parameter int            CNT_W = 11,
    parameter logic [EW-1:0] INIT  = '0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ffha_pkg::chain_ctl_t ctl,
    input  wire logic [EW-1:0]        din,
    output logic      [EW-1:0]        head,
    output logic      [CNT_W-1:0]     count
);

    logic [EW-1:0]    cell_q [N];
    logic [CNT_W-1:0] tail;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign tail = ctl.pop ? count_reg - CNT_W'(1) : count_reg;

    for (genvar j = 0; j < N; j++)
    begin : g_cell
        logic [EW-1:0] right;
        if (j == N - 1)
        begin : g_last
            assign right = din;
        end
        else
        begin : g_mid
            assign right = cell_q[j + 1];
        end

        ffha_cell #(
            .EW     (EW),
            .CNT_W  (CNT_W),
            .IDX    (j),
            .RST_VAL(INIT)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .pop  (ctl.pop),
            .push (ctl.push),
            .tail (tail),
            .din  (din),
            .right(right),
            .q    (cell_q[j])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop && !ctl.push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = cell_q[0];
    assign count = count_reg;

endmodule

`default_nettype wire

>>> src/ffha_ctrl.sv
// Request sequencer and the streaming unit that rewrites the chain in one pass.
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl #(
    parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
    localparam int OW    = $clog2(POOL_BYTES),
    localparam int SW    = $clog2(POOL_BYTES + 1),
    localparam int EW    = OW + SW + 1,
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ffha_req_if.sink                   req,
    ffha_rsp_if.source                 rsp,
    output ffha_pkg::chain_ctl_t       ctl,
    output logic      [EW-1:0]         din,
    input  wire logic [EW-1:0]         head,
    input  wire logic [CNT_W-1:0]      count
);

    localparam int CW = ffha_pkg::CALC_W;

    ffha_pkg::state_t  state_reg, state_next;
    ffha_pkg::cmd_t    cmd_reg, cmd_next;
    ffha_pkg::status_t status_reg, status_next;

    logic [ffha_pkg::NEED_W-1:0] need_reg, need_next;
    logic [ffha_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ffha_pkg::ADDR_W-1:0] granted_reg, granted_next;
    logic [CNT_W-1:0]            remain_reg, remain_next;
    logic                        split_ok_reg, split_ok_next;
    logic                        found_reg, found_next;
    logic [EW-1:0]               acc_reg, acc_next;
    logic                        acc_v_reg, acc_v_next;
    logic [EW-1:0]               pend_reg, pend_next;
    logic                        pend_v_reg, pend_v_next;
    logic [SW-1:0]               tot_reg, tot_next;
    logic [SW-1:0]               fre_reg, fre_next;

    logic                        out_valid_reg, out_valid_next;
    ffha_pkg::status_t           out_status_reg, out_status_next;
    logic [ffha_pkg::ADDR_W-1:0] out_granted_reg, out_granted_next;
    logic [ffha_pkg::SUM_W-1:0]  out_total_reg, out_total_next;
    logic [ffha_pkg::SUM_W-1:0]  out_free_reg, out_free_next;

    logic                        accept;
    logic                        is_null;
    logic [ffha_pkg::NEED_W-1:0] need_in;
    logic                        out_load;
    logic                        use_pend;
    logic                        use_head;
    logic                        have_x;
    logic [EW-1:0]               x;
    logic [OW-1:0]               x_off;
    logic [SW-1:0]               x_size;
    logic                        x_fr;
    logic [CW-1:0]               x_off_w;
    logic [CW-1:0]               x_size_w;
    logic [CW-1:0]               need_w;
    logic [CW-1:0]               hdr_w;
    logic                        alloc_hit;
    logic                        split;
    logic                        free_hit;
    logic [SW-1:0]               xp_size;
    logic                        xp_fr;
    logic [EW-1:0]               xp;
    logic [EW-1:0]               rem;
    logic                        merge;
    logic [SW-1:0]               merged_size;
    logic                        stats;

    assign accept  = req.valid && req.ready;
    assign need_in = (ffha_pkg::NEED_W'(req.request_bytes)
                      + ffha_pkg::NEED_W'(ffha_pkg::GRAN_MASK))
                     & ~ffha_pkg::NEED_W'(ffha_pkg::GRAN_MASK);

    always_comb
    begin
        is_null = 1'b1;
        case (req.command)
            ffha_pkg::CMD_ALLOC: is_null = (req.request_bytes == '0);
            ffha_pkg::CMD_FREE:  is_null = (req.payload_offset == '0);
            ffha_pkg::CMD_STATS: is_null = 1'b0;
            default:             is_null = 1'b1;
        endcase
    end

    // Item source of the streaming unit: the held split remainder comes first.
    assign use_pend = pend_v_reg;
    assign use_head = !pend_v_reg && (remain_reg != '0);
    assign have_x   = (state_reg == ffha_pkg::S_PASS) && (use_pend || use_head);
    assign x        = use_pend ? pend_reg : head;
    assign x_off    = x[EW-1 -: OW];
    assign x_size   = x[SW:1];
    assign x_fr     = x[0];

    assign x_off_w  = CW'(x_off);
    assign x_size_w = CW'(x_size);
    assign need_w   = CW'(need_reg);
    assign hdr_w    = CW'(HEADER_BYTES);

    assign alloc_hit = have_x && (cmd_reg == ffha_pkg::CMD_ALLOC) && !found_reg && x_fr
                       && (x_size_w >= need_w);
    assign split     = alloc_hit && split_ok_reg
                       && (x_size_w >= need_w + hdr_w + CW'(ffha_pkg::GRAN));
    assign free_hit  = have_x && (cmd_reg == ffha_pkg::CMD_FREE) && !found_reg
                       && (x_off_w + hdr_w == CW'(addr_reg));

    assign xp_size = split ? SW'(need_w) : x_size;
    assign xp_fr   = alloc_hit ? 1'b0 : (free_hit ? 1'b1 : x_fr);
    assign xp      = {x_off, xp_size, xp_fr};
    assign rem     = {OW'(x_off_w + hdr_w + need_w), SW'(x_size_w - need_w - hdr_w), 1'b1};

    assign merge       = have_x && (cmd_reg == ffha_pkg::CMD_FREE) && acc_v_reg
                         && acc_reg[0] && xp_fr;
    assign merged_size = SW'(CW'(acc_reg[SW:1]) + hdr_w + x_size_w);
    assign stats       = have_x && (cmd_reg == ffha_pkg::CMD_STATS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_null ? ffha_pkg::S_DONE : ffha_pkg::S_PASS;
                end
            end
            ffha_pkg::S_PASS:
            begin
                if (!have_x)
                begin
                    state_next = ffha_pkg::S_DONE;
                end
            end
            ffha_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        ctl.pop   = 1'b0;
        ctl.push  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
            end
            ffha_pkg::S_PASS:
            begin
                ctl.pop  = use_head;
                ctl.push = acc_v_reg && (!have_x || !merge);
            end
            ffha_pkg::S_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign din = acc_reg;

    always_comb
    begin
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        need_next     = need_reg;
        addr_next     = addr_reg;
        granted_next  = granted_reg;
        remain_next   = remain_reg;
        split_ok_next = split_ok_reg;
        found_next    = found_reg;
        acc_next      = acc_reg;
        acc_v_next    = acc_v_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        tot_next      = tot_reg;
        fre_next      = fre_reg;

        if (accept)
        begin
            cmd_next      = ffha_pkg::cmd_t'(req.command);
            status_next   = ffha_pkg::ST_NULL;
            need_next     = need_in;
            addr_next     = req.payload_offset;
            granted_next  = '0;
            remain_next   = count;
            split_ok_next = (count < CNT_W'(MAX_SEGMENTS));
            found_next    = 1'b0;
            acc_v_next    = 1'b0;
            pend_v_next   = 1'b0;
            tot_next      = '0;
            fre_next      = '0;
        end
        else if (state_reg == ffha_pkg::S_PASS)
        begin
            if (have_x)
            begin
                if (use_head)
                begin
                    remain_next = remain_reg - CNT_W'(1);
                end
                pend_v_next = split;
                if (split)
                begin
                    pend_next = rem;
                end
                if (alloc_hit || free_hit)
                begin
                    found_next = 1'b1;
                end
                if (alloc_hit)
                begin
                    granted_next = ffha_pkg::ADDR_W'(x_off_w + hdr_w);
                end
                if (merge)
                begin
                    acc_next = {acc_reg[EW-1 -: OW], merged_size, 1'b1};
                end
                else
                begin
                    acc_next = xp;
                end
                acc_v_next = 1'b1;
                if (stats)
                begin
                    tot_next = tot_reg + x_size;
                    if (x_fr)
                    begin
                        fre_next = fre_reg + x_size;
                    end
                end
            end
            else
            begin
                acc_v_next = 1'b0;
                case (cmd_reg)
                    ffha_pkg::CMD_ALLOC:
                        status_next = found_reg ? ffha_pkg::ST_OK : ffha_pkg::ST_NOFIT;
                    ffha_pkg::CMD_FREE:
                        status_next = found_reg ? ffha_pkg::ST_OK : ffha_pkg::ST_UNKNOWN;
                    default:
                        status_next = ffha_pkg::ST_OK;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_total_next   = out_total_reg;
        out_free_next    = out_free_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = status_reg;
            out_granted_next = granted_reg;
            out_total_next   = ffha_pkg::SUM_W'(tot_reg);
            out_free_next    = ffha_pkg::SUM_W'(fre_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            acc_v_reg     <= 1'b0;
            pend_v_reg    <= 1'b0;
            found_reg     <= 1'b0;
            remain_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_v_reg     <= acc_v_next;
            pend_v_reg    <= pend_v_next;
            found_reg     <= found_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        status_reg      <= status_next;
        need_reg        <= need_next;
        addr_reg        <= addr_next;
        granted_reg     <= granted_next;
        split_ok_reg    <= split_ok_next;
        acc_reg         <= acc_next;
        pend_reg        <= pend_next;
        tot_reg         <= tot_next;
        fre_reg         <= fre_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_total_reg   <= out_total_next;
        out_free_reg    <= out_free_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_offset = out_granted_reg;
    assign rsp.total_bytes    = out_total_reg;
    assign rsp.spare_bytes    = out_free_reg;

endmodule

`default_nettype wire

>>> src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with split and coalesce.
//
// The block keeps a byte pool as an address-ordered list of segments held in
// a row of cells that shifts like a queue. A request arrives on the req
// channel (allocate, free or statistics) and exactly one result leaves on the
// rsp channel, each handshake completing when valid and ready are both high.
// A request that does work streams every segment once through the update
// unit: entries leave the head of the row and re-enter at its tail, split,
// merged, marked or summed on the way. Its result is registered once the pass
// has ended, a held split remainder included, and the input reopens when
// that result is loaded into the output register. A null request or an
// unused command skips the pass and goes straight to its result.
// One request is worked on at a time; a new one is taken as soon as the
// previous result has reached the output register, even while it waits there.
// When the receiver stalls, the result holds on rsp and the next finished
// result waits inside until the output register is free.
// Reset leaves one free segment spanning the whole pool and no result.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator #(
    parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);

    localparam int OW    = $clog2(POOL_BYTES);
    localparam int SW    = $clog2(POOL_BYTES + 1);
    localparam int EW    = OW + SW + 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [EW-1:0] INIT = {OW'(0), SW'(POOL_BYTES - HEADER_BYTES), 1'b1};

    ffha_pkg::chain_ctl_t ctl;
    logic [EW-1:0]        din;
    logic [EW-1:0]        head;
    logic [CNT_W-1:0]     count;

    ffha_chain #(
        .N    (MAX_SEGMENTS),
        .EW   (EW),
        .CNT_W(CNT_W),
        .INIT (INIT)
    ) u_chain (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .din  (din),
        .head (head),
        .count(count)
    );

    ffha_ctrl #(
        .POOL_BYTES  (POOL_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .ctl  (ctl),
        .din  (din),
        .head (head),
        .count(count)
    );

endmodule

`default_nettype wire

>>> src/ffha_checker.sv
// Port-level assertions for the first-fit heap allocator and their binding.
`timescale 1ns / 1ps
`default_nettype none

module ffha_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [1:0]                  rsp_status,
    input wire logic [ffha_pkg::ADDR_W-1:0] rsp_granted,
    input wire logic [ffha_pkg::SUM_W-1:0]  rsp_total,
    input wire logic [ffha_pkg::SUM_W-1:0]  rsp_spare
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ffha_pkg::ST_OK) |->
        (rsp_granted == '0) && (rsp_total == '0) && (rsp_spare == '0))
        else $error("failed request carries data");

    a_grant_no_stats: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_granted != '0) |->
        (rsp_status == ffha_pkg::ST_OK) && (rsp_total == '0) && (rsp_spare == '0))
        else $error("grant mixed with statistics");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_granted(rsp.granted_offset),
    .rsp_total  (rsp.total_bytes),
    .rsp_spare  (rsp.spare_bytes)
);

`default_nettype wire
